// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/wdq_pkg.sv =====
// ----------------------------------------------------------------------------
// wdq_pkg
// types and constants of the watermark discard queue
// ----------------------------------------------------------------------------
package wdq_pkg;

    localparam int DATA_W  = 32;
    localparam int ENTRY_W = DATA_W + 1;
    localparam int QLEN_W  = 9;
    localparam int MARK_W  = 9;
    localparam int ERR_W   = 2;

    localparam logic [MARK_W-1:0] HIGH_MARK_RST = 9'd192;
    localparam logic [MARK_W-1:0] LOW_MARK_RST  = 9'd64;

    // register index, taken from paddr bit 2
    localparam logic REG_HIGH_MARK = 1'b0;
    localparam logic REG_LOW_MARK  = 1'b1;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic              operation;
        logic              force_req;
        logic [DATA_W-1:0] record;
    } t_cmd;

    typedef struct packed {
        logic              accepted;
        logic              report_queued;
        logic              wake_consumer;
        logic              head_valid;
        logic              head_is_report;
        logic [DATA_W-1:0] head_value;
        logic [QLEN_W-1:0] queue_length;
        logic              discarding;
        logic [DATA_W-1:0] discard_count;
        logic [ERR_W-1:0]  error;
    } t_res;

endpackage

// ===== sv/wdq_ram.sv =====
// ----------------------------------------------------------------------------
// wdq_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wdq_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/watermark_discard_queue.sv =====
// ----------------------------------------------------------------------------
// watermark_discard_queue
// record fifo with high/low watermark hysteresis admission and discard reports
// ----------------------------------------------------------------------------
// channel   dir  handshake                       payload
// command   in   start && !busy                  i_cmd  (t_cmd)
// result    out  o_valid, one cycle, no stall    o_res  (t_res)
// config    in   psel && penable && pwrite       paddr, pwdata / prdata
//
// an item passes the accept and execute states, plus S_REC when a discard
// report and the record are both pushed: the entry ram has a single write port
// a dequeue reads the new head in the accept cycle, data returns in execute
// the result strobe is registered after the last state; the next item may be accepted
// in the same cycle that o_valid is high
// reset is synchronous; the entry ram is not cleared, only data of occupied
// entries reaches o_res, though free slots may also be read
// ----------------------------------------------------------------------------
module watermark_discard_queue
    import wdq_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  t_cmd                i_cmd,
    // result channel
    output logic                o_valid,
    output t_res                o_res,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > MARK_W) ? CW : MARK_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_REC  = 2'd2;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic [AW-1:0]     r_addr2, n_addr2;
    logic [CW-1:0]     r_count, n_count;
    logic              r_mode, n_mode;
    logic [DATA_W-1:0] r_total, n_total;
    logic [MARK_W-1:0] r_high, r_low;
    t_res              r_res, n_res;
    logic              r_valid;
    logic              two_writes;

    logic               accept;
    logic               cfg_wr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOW_MARK) ? DATA_W'(r_low) : DATA_W'(r_high);

    wdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (f_inc(r_head)),
        .o_rdata (ram_rdata)
    );

    // execute step: admission decision, pointer update, ram writes, next state and result
    always_comb begin
        logic [CW-1:0] cnt1;
        logic [AW-1:0] tail1;
        logic          dropped;
        logic          rep_push;
        logic          rec_push;

        cnt1     = r_count;
        tail1    = r_tail;
        dropped  = 1'b0;
        rep_push = 1'b0;
        rec_push = 1'b0;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_mode   = r_mode;
        n_total  = r_total;
        n_res    = '0;

        if (r_cmd.operation == OP_DEQ) begin
            if (r_count == '0) begin
                n_res.error = ERR_EMPTY;
            end else begin
                n_head  = f_inc(r_head);
                n_count = r_count - 1'b1;
                if (r_count != CW'(1)) begin
                    n_res.head_valid     = 1'b1;
                    n_res.head_is_report = ram_rdata[DATA_W];
                    n_res.head_value     = ram_rdata[DATA_W-1:0];
                end
            end
        end else begin
            if (r_mode && !r_cmd.force_req) begin
                if (CMPW'(r_count) < CMPW'(r_low)) begin
                    n_mode = 1'b0;
                    if (r_count < CW'(DEPTH)) begin
                        rep_push = 1'b1;
                        n_total  = '0;
                        cnt1     = r_count + 1'b1;
                        tail1    = f_inc(r_tail);
                    end else begin
                        n_res.error = ERR_FULL;
                    end
                end else begin
                    dropped = 1'b1;
                    if (r_total != '1) begin
                        n_total = r_total + 1'b1;
                    end
                end
            end
            if (!dropped) begin
                if (r_cmd.force_req) begin
                    if (cnt1 < CW'(DEPTH)) begin
                        rec_push = 1'b1;
                    end else begin
                        n_res.error = ERR_FULL;
                    end
                end else if (CMPW'(cnt1) < CMPW'(r_high) && cnt1 < CW'(DEPTH)) begin
                    rec_push = 1'b1;
                end else begin
                    n_mode = 1'b1;
                end
            end
            n_tail  = rec_push ? f_inc(tail1) : tail1;
            n_count = cnt1 + CW'(rec_push);
            n_res.accepted      = rec_push;
            n_res.report_queued = rep_push;
            n_res.wake_consumer = (rep_push && r_count == '0) || (rec_push && cnt1 == '0);
        end

        n_res.queue_length  = QLEN_W'(n_count);
        n_res.discarding    = n_mode;
        n_res.discard_count = n_total;

        two_writes = rep_push && rec_push;
        n_addr2    = tail1;

        // report goes first; a record alone is written right away
        ram_we    = 1'b0;
        ram_waddr = r_tail;
        ram_wdata = rep_push ? {1'b1, r_total} : {1'b0, r_cmd.record};
        n_state   = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                ram_we  = rep_push || rec_push;
                n_state = two_writes ? S_REC : S_IDLE;
            end
            S_REC: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr2;
                ram_wdata = {1'b0, r_cmd.record};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_mode  <= 1'b0;
            r_total <= '0;
            r_high  <= HIGH_MARK_RST;
            r_low   <= LOW_MARK_RST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= ((r_state == S_EXEC) && !two_writes) || (r_state == S_REC);
            if (r_state == S_EXEC) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_mode  <= n_mode;
                r_total <= n_total;
            end
            if (cfg_wr) begin
                if (paddr[2] == REG_LOW_MARK) begin
                    r_low <= pwdata[MARK_W-1:0];
                end else begin
                    r_high <= pwdata[MARK_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EXEC) begin
            r_res   <= n_res;
            r_addr2 <= n_addr2;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/wdq_checker.sv =====
// ----------------------------------------------------------------------------
// wdq_checker
// port-level checks of the watermark discard queue, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdq_checker
    import wdq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input t_res o_res
);

    logic deq_on_empty;
    logic empty_no_head;
    logic rec_stored;

    assign deq_on_empty  = o_valid && o_res.error == ERR_EMPTY;
    assign empty_no_head = o_res.queue_length == '0 && !o_res.head_valid && !o_res.accepted;
    assign rec_stored    = o_valid && o_res.accepted;

    // an accepted item makes the block busy in the following cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // a result is only shown once the item has finished
    `ASSERT_IMPLY(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)

    // each item yields a single one-cycle result
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)

    // dequeue on empty leaves an empty queue and no head
    `ASSERT_IMPLY(a_empty_deq, i_clk, i_rst_n, deq_on_empty, empty_no_head)

    // a stored record never comes with a full-store error
    `ASSERT_IMPLY(a_accept_no_full, i_clk, i_rst_n, rec_stored, o_res.error == ERR_NONE)

endmodule

bind watermark_discard_queue wdq_checker u_wdq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the watermark discard queue: a short scripted
// sequence, then random enqueue/dequeue bursts under several mark settings
// and sender gap rates, results checked against typed values or a queue predictor
// ----------------------------------------------------------------------------
module tb;
    import wdq_pkg::*;

    localparam int DEPTH       = 256;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 4;
    localparam int DRAIN_LIMIT = 2000;

    typedef struct {
        int high;
        int low;
        int gap;
        int items;
        int burst;
    } t_phase;

    typedef struct {
        t_cmd cmd;
        bit   has_exp;
        t_res exp;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_cmd              i_cmd;
    logic              o_valid;
    t_res              o_res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state
    logic [ENTRY_W-1:0] q_store [DEPTH];
    logic [PTR_W-1:0]   q_head;
    logic [PTR_W-1:0]   q_tail;
    logic [QLEN_W-1:0]  q_count;
    logic               q_disc;
    logic [DATA_W-1:0]  q_dropped;
    logic [MARK_W-1:0]  mark_high;
    logic [MARK_W-1:0]  mark_low;

    t_res expected_status[$];
    int   fail_count  = 0;
    int   cycle_count = 0;
    int   gap_pct     = 0;
    bit   script_typed;
    t_res script_status;

    t_phase plan [6] = '{
        '{192, 64,  0, 300,  60},
        '{16,  4,  70, 300,  40},
        '{256, 256, 7, 350, 300},
        '{0,   0,   0, 200,  40},
        '{4,   12, 70, 300,  30},
        '{0,   0,   7, 300,  60}
    };

    watermark_discard_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_cmd cmd_of(logic op, logic frc, logic [DATA_W-1:0] rec);
        return t_cmd'({op, frc, rec});
    endfunction

    function automatic t_res make_res(
        input logic acc, rep, wake, hv, hk,
        input logic [DATA_W-1:0] hval,
        input logic [QLEN_W-1:0] qlen,
        input logic disc,
        input logic [DATA_W-1:0] cnt,
        input logic [ERR_W-1:0] err
    );
        return t_res'({acc, rep, wake, hv, hk, hval, qlen, disc, cnt, err});
    endfunction

    function automatic bit push_entry(logic [ENTRY_W-1:0] e, inout logic wake);
        if (q_count >= DEPTH) begin
            return 1'b0;
        end
        q_store[q_tail] = e;
        q_tail = q_tail + 1'b1;
        q_count = q_count + 1'b1;
        if (q_count == 1) begin
            wake = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic t_res queue_step(t_cmd c);
        logic               acc, rep, wake, hv, hk, drop;
        logic [DATA_W-1:0]  hval;
        logic [ERR_W-1:0]   err;
        logic [ENTRY_W-1:0] e;
        acc  = 1'b0;
        rep  = 1'b0;
        wake = 1'b0;
        hv   = 1'b0;
        hk   = 1'b0;
        drop = 1'b0;
        hval = '0;
        err  = ERR_NONE;
        if (c.operation == OP_DEQ) begin
            if (q_count == 0) begin
                err = ERR_EMPTY;
            end else begin
                q_head = q_head + 1'b1;
                q_count = q_count - 1'b1;
                if (q_count != 0) begin
                    e    = q_store[q_head];
                    hv   = 1'b1;
                    hk   = e[DATA_W];
                    hval = e[DATA_W-1:0];
                end
            end
        end else begin
            if (q_disc && !c.force_req) begin
                if (q_count < mark_low) begin
                    // leaving discard mode queues a report ahead of the record
                    q_disc = 1'b0;
                    if (push_entry({1'b1, q_dropped}, wake)) begin
                        rep = 1'b1;
                        q_dropped = '0;
                    end else begin
                        err = ERR_FULL;
                    end
                end else begin
                    if (q_dropped != '1) begin
                        q_dropped = q_dropped + 1'b1;
                    end
                    drop = 1'b1;
                end
            end
            if (!drop) begin
                if (c.force_req) begin
                    if (push_entry({1'b0, c.record}, wake)) begin
                        acc = 1'b1;
                    end else begin
                        err = ERR_FULL;
                    end
                end else if (q_count < mark_high && q_count < DEPTH) begin
                    acc = push_entry({1'b0, c.record}, wake);
                end else begin
                    q_disc = 1'b1;
                end
            end
        end
        return make_res(acc, rep, wake, hv, hk, hval, q_count, q_disc, q_dropped, err);
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    task automatic check_status(t_res got, t_res want);
        if (got.accepted !== want.accepted)
            note_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
        if (got.report_queued !== want.report_queued)
            note_mismatch("report_queued", 64'(got.report_queued),
                          64'(want.report_queued));
        if (got.wake_consumer !== want.wake_consumer)
            note_mismatch("wake_consumer", 64'(got.wake_consumer),
                          64'(want.wake_consumer));
        if (got.head_valid !== want.head_valid)
            note_mismatch("head_valid", 64'(got.head_valid), 64'(want.head_valid));
        if (got.head_is_report !== want.head_is_report)
            note_mismatch("head_is_report", 64'(got.head_is_report),
                          64'(want.head_is_report));
        if (got.head_value !== want.head_value)
            note_mismatch("head_value", 64'(got.head_value), 64'(want.head_value));
        if (got.queue_length !== want.queue_length)
            note_mismatch("queue_length", 64'(got.queue_length), 64'(want.queue_length));
        if (got.discarding !== want.discarding)
            note_mismatch("discarding", 64'(got.discarding), 64'(want.discarding));
        if (got.discard_count !== want.discard_count)
            note_mismatch("discard_count", 64'(got.discard_count),
                          64'(want.discard_count));
        if (got.error !== want.error)
            note_mismatch("error", 64'(got.error), 64'(want.error));
    endtask

    // result check first: the oldest item always finishes before a new one
    always @(posedge i_clk) begin
        t_res predicted;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_status.size() == 0) begin
                    note_mismatch("unexpected result", 64'd1, 64'd0);
                end else begin
                    check_status(o_res, expected_status.pop_front());
                end
            end
            if (start && !busy) begin
                predicted = queue_step(i_cmd);
                expected_status.push_back(script_typed ? script_status : predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(t_cmd c, bit typed, t_res status);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= c;
        script_typed  <= typed;
        script_status <= status;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_status.size() != 0) begin
            note_mismatch("results still outstanding", 64'(expected_status.size()), 64'd0);
            expected_status.delete();
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // write, then read back; upper data bits are junk the block must ignore
    task automatic write_mark(logic idx, logic [MARK_W-1:0] val);
        logic [DATA_W-1:0] word;
        word = $urandom;
        word[MARK_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_HIGH_MARK) begin
            mark_high = val;
        end else begin
            mark_low = val;
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[MARK_W-1:0] !== val) begin
            note_mismatch("mark readback", 64'(prdata), 64'(val));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        t_stim_row script[$];
        t_cmd      c;
        int        sent, burst_left, enq_pct, frc_pct, pause_at, kind, roll;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        script_typed  = 1'b0;
        script_status = '0;
        q_head        = '0;
        q_tail        = '0;
        q_count       = '0;
        q_disc        = 1'b0;
        q_dropped     = '0;
        mark_high     = HIGH_MARK_RST;
        mark_low      = LOW_MARK_RST;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // tiny marks so discarding and the report show up within a few items
        write_mark(REG_HIGH_MARK, 9'd3);
        write_mark(REG_LOW_MARK, 9'd2);

        script.push_back('{cmd_of(OP_DEQ, 1'b0, '0), 1'b1,
                           make_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0,
                                    ERR_EMPTY)});
        script.push_back('{cmd_of(OP_ENQ, 1'b0, '1), 1'b1,
                           make_res(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0, 9'd1, 1'b0, '0,
                                    ERR_NONE)});
        script.push_back('{cmd_of(OP_ENQ, 1'b0, '0), 1'b1,
                           make_res(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0, 9'd2, 1'b0, '0,
                                    ERR_NONE)});
        script.push_back('{cmd_of(OP_ENQ, 1'b0, 32'hA5A5_A5A5), 1'b0, '0});
        script.push_back('{cmd_of(OP_ENQ, 1'b0, 32'h5A5A_5A5A), 1'b1,
                           make_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 9'd3, 1'b1, '0,
                                    ERR_NONE)});
        script.push_back('{cmd_of(OP_ENQ, 1'b0, 32'h1234_5678), 1'b0, '0});
        script.push_back('{cmd_of(OP_ENQ, 1'b1, 32'h8000_0001), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b0, 32'hFFFF_0000), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b1, '0), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b0, '0), 1'b0, '0});
        // below the low mark: report goes in ahead of this record
        script.push_back('{cmd_of(OP_ENQ, 1'b0, 32'h0F0F_0F0F), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b0, '0), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b0, '0), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b0, '0), 1'b0, '0});
        script.push_back('{cmd_of(OP_DEQ, 1'b1, '1), 1'b1,
                           make_res(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0,
                                    ERR_EMPTY)});
        script.push_back('{cmd_of(OP_ENQ, 1'b1, '1), 1'b1,
                           make_res(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0, 9'd1, 1'b0, '0,
                                    ERR_NONE)});
        script.push_back('{cmd_of(OP_DEQ, 1'b0, '0), 1'b0, '0});

        foreach (script[i]) begin
            send_item(script[i].cmd, script[i].has_exp, script[i].exp);
        end
        hold_until_drained();

        plan[5].high = $urandom_range(0, 256);
        plan[5].low  = $urandom_range(0, 256);

        foreach (plan[p]) begin
            gap_pct = plan[p].gap;
            write_mark(REG_HIGH_MARK, MARK_W'(plan[p].high));
            write_mark(REG_LOW_MARK, MARK_W'(plan[p].low));
            pause_at   = $urandom_range(plan[p].items / 4, plan[p].items * 3 / 4);
            sent       = 0;
            burst_left = 0;
            while (sent < plan[p].items) begin
                if (burst_left == 0) begin
                    // fill, drain, mixed and force-heavy noise bursts
                    kind       = $urandom_range(9);
                    burst_left = $urandom_range(5, plan[p].burst);
                    frc_pct    = 15;
                    if (kind < 4) begin
                        enq_pct = 95;
                    end else if (kind < 7) begin
                        enq_pct = 5;
                    end else if (kind < 9) begin
                        enq_pct = 50;
                    end else begin
                        enq_pct = 50;
                        frc_pct = 60;
                    end
                end
                c.operation = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
                c.force_req = ($urandom_range(99) < frc_pct);
                roll        = $urandom_range(15);
                c.record    = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
                send_item(c, 1'b0, '0);
                sent++;
                burst_left--;
                if (sent == pause_at) begin
                    hold_until_drained();
                end
            end
            hold_until_drained();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wdq_pkg.sv
sv/wdq_ram.sv
sv/watermark_discard_queue.sv
sv/wdq_checker.sv
test/tb.sv
